>>> rtl/core/trrs_pkg.sv
// Shared types and codes for the round-robin thread scheduler.
// Request modes, result status codes and per-slot thread states.
// No dependencies.
`default_nettype none

package trrs_pkg;

  localparam int unsigned ModeW   = 3;
  localparam int unsigned IdxW    = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned TsW     = 2;

  typedef logic [ModeW-1:0]   mode_t;
  typedef logic [IdxW-1:0]    idx_t;
  typedef logic [StatusW-1:0] status_t;
  typedef logic [TsW-1:0]     tstate_t;

  // request modes
  localparam mode_t MODE_ADD   = 3'd0;
  localparam mode_t MODE_TERM  = 3'd1;
  localparam mode_t MODE_YIELD = 3'd2;
  localparam mode_t MODE_JOIN  = 3'd3;
  localparam mode_t MODE_SCHED = 3'd4;

  // result status
  localparam status_t STAT_OK       = 2'd0;
  localparam status_t STAT_FULL     = 2'd1;
  localparam status_t STAT_NONE_RUN = 2'd2;
  localparam status_t STAT_ALL_TERM = 2'd3;

  // per-slot thread state
  localparam tstate_t TS_NORMAL = 2'd0;
  localparam tstate_t TS_TERM   = 2'd1;
  localparam tstate_t TS_YIELD  = 2'd2;
  localparam tstate_t TS_JOIN   = 2'd3;

endpackage

`default_nettype wire

>>> rtl/core/trrs_ram.sv
// Single write port, single read port RAM with a registered read.
// A read of the entry written in the same cycle returns the new data.
// No dependencies.
`default_nettype none

module trrs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire [$clog2(Depth)-1:0]   waddr_i,
  input  wire [Width-1:0]           wdata_i,
  input  wire [$clog2(Depth)-1:0]   raddr_i,
  output logic [Width-1:0]          rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/trrs_urem.sv
// Iterative unsigned remainder, one quotient bit per cycle (restoring).
// Used to fold the schedule start slot into the occupied range.
// No dependencies.
`default_nettype none

module trrs_urem #(
  parameter int unsigned NumW = 8,
  parameter int unsigned DenW = 9
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start_i,
  input  wire [NumW-1:0]   num_i,
  input  wire [DenW-1:0]   den_i,
  output logic             done_o,
  output logic [NumW-1:0]  rem_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic            done_q, done_d;
  logic [DenW:0]   shifted;

  always_comb begin
    shifted = {rem_q, quo_q[NumW-1]};
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    done_d  = 1'b0;
    if (start_i) begin
      cnt_d = CntW'(NumW);
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
    end else if (cnt_q != '0) begin
      if (shifted >= {1'b0, den_q}) begin
        rem_d = DenW'(shifted - {1'b0, den_q});
      end else begin
        rem_d = shifted[DenW-1:0];
      end
      quo_d  = quo_q << 1;
      cnt_d  = cnt_q - CntW'(1);
      done_d = (cnt_q == CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  // remainder is below the divisor, so it fits the dividend width
  assign done_o = done_q;
  assign rem_o  = NumW'(rem_q);

endmodule

`default_nettype wire

>>> rtl/core/thread_round_robin_scheduler.sv
// Round-robin hardware thread scheduler: top level with the request sequencer.
// Depends on trrs_pkg, trrs_ram (thread state and join partner tables) and
// trrs_urem (start slot folding).
//
// Usage: one request channel (mode_i, thread_index_i, partner_index_i) and one
// result channel (status_o, chosen_index_o), both valid/ready. Every request
// gives exactly one result. Requests are handled one at a time; in_ready_o is
// high whenever the sequencer is idle, even while a result waits on the output.
// States from acceptance to out_valid_o, each path ending in S_EMIT:
//   add, unknown mode, out-of-range slot, empty/all-terminated schedule: S_EMIT only
//   terminate, yield, join on a live slot: S_RMW (table read-modify-write)
//   schedule: S_MOD first if the start slot lies beyond the occupied range and
//   is folded by the remainder unit, then S_WALK for each of V slots visited
//   (at most 2 * thread count) and S_JCHK for each of J joiners whose partner
//   state had to be read. The walk is set by the single table read port: one
//   slot per cycle, apart from the partner reads of joiners.
// Reset empties the table and sets the last pick to the final slot, so the
// first schedule starts at slot 0. The tables are not cleared; every slot is
// written by add before use. If the receiver stalls, the result is held in
// the output register and the next result waits inside the sequencer.
`default_nettype none

module thread_round_robin_scheduler #(
  parameter int unsigned MaxThreads = 256
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire trrs_pkg::mode_t mode_i,
  input  wire trrs_pkg::idx_t  thread_index_i,
  input  wire trrs_pkg::idx_t  partner_index_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output trrs_pkg::status_t   status_o,
  output trrs_pkg::idx_t      chosen_index_o
);

  import trrs_pkg::*;

  localparam int unsigned SW = $clog2(MaxThreads);
  localparam int unsigned CW = $clog2(MaxThreads + 1);
  localparam int unsigned XW = (CW > IdxW) ? CW : IdxW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RMW  = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_JCHK = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] alive_q, alive_d;
  logic [SW-1:0] cur_q, cur_d;
  logic [SW-1:0] slot_q, slot_d;
  logic [CW:0]   visits_q, visits_d;
  mode_t         mode_q, mode_d;
  idx_t          tidx_q, tidx_d;
  idx_t          pidx_q, pidx_d;
  status_t       pend_status_q, pend_status_d;
  idx_t          pend_idx_q, pend_idx_d;
  logic          out_valid_q, out_valid_d;
  status_t       out_status_q, out_status_d;
  idx_t          out_idx_q, out_idx_d;

  // table ports
  logic          st_we, pt_we;
  logic [SW-1:0] st_waddr, pt_waddr, rd_addr;
  tstate_t       st_wdata, st_rdata;
  idx_t          pt_wdata, pt_rdata;

  logic          urem_start, urem_done;
  logic [SW-1:0] urem_rem;

  logic          t_live;
  logic [SW-1:0] start_slot, slot_nxt;
  logic          take, adv;

  trrs_ram #(
    .Width (TsW),
    .Depth (MaxThreads)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (rd_addr),
    .rdata_o (st_rdata)
  );

  trrs_ram #(
    .Width (IdxW),
    .Depth (MaxThreads)
  ) u_partner_ram (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .waddr_i (pt_waddr),
    .wdata_i (pt_wdata),
    .raddr_i (rd_addr),
    .rdata_o (pt_rdata)
  );

  trrs_urem #(
    .NumW (SW),
    .DenW (CW)
  ) u_urem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (urem_start),
    .num_i   (start_slot),
    .den_i   (count_q),
    .done_o  (urem_done),
    .rem_o   (urem_rem)
  );

  assign t_live     = XW'(thread_index_i) < XW'(count_q);
  assign start_slot = (cur_q == SW'(MaxThreads - 1)) ? '0 : SW'(cur_q + SW'(1));
  assign slot_nxt   = ((CW'(slot_q) + CW'(1)) >= count_q) ? '0 : SW'(slot_q + SW'(1));

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    alive_d       = alive_q;
    cur_d         = cur_q;
    slot_d        = slot_q;
    visits_d      = visits_q;
    mode_d        = mode_q;
    tidx_d        = tidx_q;
    pidx_d        = pidx_q;
    pend_status_d = pend_status_q;
    pend_idx_d    = pend_idx_q;
    out_valid_d   = out_valid_q;
    out_status_d  = out_status_q;
    out_idx_d     = out_idx_q;
    st_we         = 1'b0;
    st_waddr      = slot_q;
    st_wdata      = TS_NORMAL;
    pt_we         = 1'b0;
    pt_waddr      = slot_q;
    pt_wdata      = '0;
    rd_addr       = slot_q;
    urem_start    = 1'b0;
    take          = 1'b0;
    adv           = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        rd_addr = SW'(thread_index_i);
        if (in_valid_i) begin
          mode_d        = mode_i;
          tidx_d        = thread_index_i;
          pidx_d        = partner_index_i;
          pend_status_d = STAT_OK;
          pend_idx_d    = '0;
          state_d       = S_EMIT;
          unique case (mode_i)
            MODE_ADD: begin
              if (count_q == CW'(MaxThreads)) begin
                pend_status_d = STAT_FULL;
              end else begin
                st_we      = 1'b1;
                st_waddr   = SW'(count_q);
                st_wdata   = TS_NORMAL;
                pt_we      = 1'b1;
                pt_waddr   = SW'(count_q);
                pt_wdata   = '0;
                count_d    = count_q + CW'(1);
                alive_d    = alive_q + CW'(1);
                pend_idx_d = IdxW'(count_q);
              end
            end
            MODE_TERM, MODE_YIELD, MODE_JOIN: begin
              if (t_live) begin
                state_d = S_RMW;
              end
            end
            MODE_SCHED: begin
              if (count_q == '0) begin
                pend_status_d = STAT_NONE_RUN;
              end else if (alive_q == '0) begin
                count_d       = '0;
                pend_status_d = STAT_ALL_TERM;
              end else if (CW'(start_slot) >= count_q) begin
                urem_start = 1'b1;
                state_d    = S_MOD;
              end else begin
                slot_d   = start_slot;
                rd_addr  = start_slot;
                visits_d = '0;
                state_d  = S_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_RMW: begin
        st_waddr = SW'(tidx_q);
        pt_waddr = SW'(tidx_q);
        unique case (mode_q)
          MODE_TERM: begin
            st_we    = 1'b1;
            st_wdata = TS_TERM;
            if (st_rdata != TS_TERM) begin
              alive_d = alive_q - CW'(1);
            end
          end
          MODE_YIELD: begin
            if (st_rdata != TS_TERM) begin
              st_we    = 1'b1;
              st_wdata = TS_YIELD;
            end
          end
          MODE_JOIN: begin
            if (st_rdata != TS_TERM) begin
              st_we    = 1'b1;
              st_wdata = TS_JOIN;
              pt_we    = 1'b1;
              pt_wdata = pidx_q;
            end
          end
          default: begin
          end
        endcase
        state_d = S_EMIT;
      end

      S_MOD: begin
        if (urem_done) begin
          slot_d   = urem_rem;
          rd_addr  = urem_rem;
          visits_d = '0;
          state_d  = S_WALK;
        end
      end

      S_WALK: begin
        case (st_rdata)
          TS_YIELD: begin
            // clear the yield mark and move on
            st_we    = 1'b1;
            st_waddr = slot_q;
            st_wdata = TS_NORMAL;
            adv      = 1'b1;
          end
          TS_NORMAL: take = 1'b1;
          TS_TERM:   adv  = 1'b1;
          TS_JOIN: begin
            if (XW'(pt_rdata) >= XW'(count_q)) begin
              take = 1'b1;
            end else begin
              rd_addr = SW'(pt_rdata);
              state_d = S_JCHK;
            end
          end
        endcase
      end

      S_JCHK: begin
        if (st_rdata == TS_TERM) begin
          take = 1'b1;
        end else begin
          adv = 1'b1;
        end
      end

      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = pend_status_q;
          out_idx_d    = pend_idx_q;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    if (take) begin
      cur_d         = slot_q;
      pend_status_d = STAT_OK;
      pend_idx_d    = IdxW'(slot_q);
      state_d       = S_EMIT;
    end else if (adv) begin
      if ((visits_q + (CW + 1)'(1)) == {count_q, 1'b0}) begin
        pend_status_d = STAT_NONE_RUN;
        pend_idx_d    = '0;
        state_d       = S_EMIT;
      end else begin
        slot_d   = slot_nxt;
        rd_addr  = slot_nxt;
        visits_d = visits_q + (CW + 1)'(1);
        state_d  = S_WALK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      alive_q     <= '0;
      cur_q       <= SW'(MaxThreads - 1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      alive_q     <= alive_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q        <= slot_d;
    visits_q      <= visits_d;
    mode_q        <= mode_d;
    tidx_q        <= tidx_d;
    pidx_q        <= pidx_d;
    pend_status_q <= pend_status_d;
    pend_idx_q    <= pend_idx_d;
    out_status_q  <= out_status_d;
    out_idx_q     <= out_idx_d;
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign chosen_index_o = out_idx_q;

endmodule

`default_nettype wire
